FILE: rtl/ccd_pkg.sv
// shared constants and types for the camera cut detector
package ccd_pkg;

   // default width of one coordinate, signed with 4 fraction bits
   localparam int COORD_BITS_DEFAULT = 20;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int LIMIT_BITS     = 16;
   localparam int LIMIT_SQ_BITS  = 2 * LIMIT_BITS;

   // distance components saturate here before squaring
   localparam int SAT_LIMIT = 65536;
   localparam int SAT_BITS  = 17;
   localparam int SQ_BITS   = 2 * SAT_BITS - 1;
   localparam int SUM_BITS  = SQ_BITS + 1;

   // limit reset values
   localparam logic [LIMIT_BITS-1:0] VEL_MATCH_RESET = 16'd48;
   localparam logic [LIMIT_BITS-1:0] STILL_RESET     = 16'd160;
   localparam logic [LIMIT_BITS-1:0] JUMP_RESET      = 16'd800;
   localparam logic [LIMIT_BITS-1:0] NEAR_RESET      = 16'd1600;
   localparam logic [LIMIT_BITS-1:0] FAR_RESET       = 16'd4800;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VEL_MATCH = 3'd0,
      CSR_STILL     = 3'd1,
      CSR_JUMP      = 3'd2,
      CSR_NEAR      = 3'd3,
      CSR_FAR       = 3'd4
   } csr_index_type;

   // per-request control flags carried down the pipeline
   typedef struct packed {
      logic tracked;
      logic force_interp;
      logic force_cut;
   } flags_type;

   // squared limit of a 16 bit limit
   function automatic logic [LIMIT_SQ_BITS-1:0] limit_sq(input logic [LIMIT_BITS-1:0] lim);
      return LIMIT_SQ_BITS'(lim) * LIMIT_SQ_BITS'(lim);
   endfunction

endpackage

FILE: rtl/ccd_if.sv
// request and response channel interfaces of the camera cut detector

interface ccd_req_if #(
   parameter int COORD_BITS = ccd_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] eye_x;
   logic signed [COORD_BITS-1:0] eye_y;
   logic signed [COORD_BITS-1:0] eye_z;
   logic signed [COORD_BITS-1:0] at_x;
   logic signed [COORD_BITS-1:0] at_y;
   logic signed [COORD_BITS-1:0] at_z;
   logic                         perspective;
   logic                         ignore_tracking;
   logic                         force_interpolate;
   logic                         force_skip;
   logic                         leaving_pause;

   modport source (
      output valid, eye_x, eye_y, eye_z, at_x, at_y, at_z,
             perspective, ignore_tracking, force_interpolate, force_skip, leaving_pause,
      input  ready
   );

   modport sink (
      input  valid, eye_x, eye_y, eye_z, at_x, at_y, at_z,
             perspective, ignore_tracking, force_interpolate, force_skip, leaving_pause,
      output ready
   );
endinterface

interface ccd_rsp_if;
   logic valid;
   logic ready;
   logic interpolate;
   logic tracking_reset;

   modport source (
      output valid, interpolate, tracking_reset,
      input  ready
   );

   modport sink (
      input  valid, interpolate, tracking_reset,
      output ready
   );
endinterface

FILE: rtl/camera_cut_detector.sv
// camera cut detector: per-frame smooth motion versus cut decision
//
// Takes one request per cycle sustained while the response side is not stalled and
// returns one response per request. Stage one holds the accepted request and squares
// the saturated prediction errors and the eye/look-at velocity difference; stage two
// sums the squares and compares them with the squared limits; the response register
// follows. The velocity clear decided in stage two feeds straight back into stage one,
// which squares the eye and look-at errors both with and without the stored velocity
// and keeps the pair that matches, so consecutive frames see the cleared velocities
// at once. Limits are stored squared; the user must write them only while no request
// is in flight, which the block itself does not enforce.
module camera_cut_detector #(
   parameter int COORD_BITS = ccd_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   ccd_req_if.sink                             req_ch,
   ccd_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [ccd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ccd_pkg::LIMIT_BITS-1:0]      csr_wdata
);
   import ccd_pkg::*;

   localparam int MOT_W = COORD_BITS + 1;
   localparam int ERR_W = COORD_BITS + 3;
   localparam int MAG_W = ERR_W + SAT_BITS;

   // saturated magnitude of one error component
   function automatic logic [SAT_BITS-1:0] sat_mag(input logic signed [ERR_W-1:0] d);
      logic [ERR_W-1:0] mag;
      logic [MAG_W-1:0] wide;
      mag  = d[ERR_W-1] ? ERR_W'(-d) : ERR_W'(d);
      wide = MAG_W'(mag);
      if (wide > MAG_W'(SAT_LIMIT)) begin
         return SAT_BITS'(SAT_LIMIT);
      end
      return wide[SAT_BITS-1:0];
   endfunction

   // square of a saturated component
   function automatic logic [SQ_BITS-1:0] sq(input logic [SAT_BITS-1:0] m);
      return SQ_BITS'(m) * SQ_BITS'(m);
   endfunction

   // squared limits
   logic [LIMIT_SQ_BITS-1:0] vel_sq_ff, still_sq_ff, jump_sq_ff, near_sq_ff, far_sq_ff;

   // tracking state
   logic signed [COORD_BITS-1:0] last_eye_ff [3];
   logic signed [COORD_BITS-1:0] last_at_ff [3];
   logic signed [MOT_W-1:0]      eye_mot_ff [3];
   logic signed [MOT_W-1:0]      at_mot_ff [3];

   // stage one: accepted request
   logic                         b_valid_ff, b_valid_in;
   flags_type                    b_flags_ff;
   logic signed [COORD_BITS-1:0] b_eye_ff [3];
   logic signed [COORD_BITS-1:0] b_at_ff [3];

   // stage two: squared components
   logic                c_valid_ff, c_valid_in;
   flags_type           c_flags_ff;
   logic [SQ_BITS-1:0]  c_e_sq_ff [3];
   logic [SQ_BITS-1:0]  c_a_sq_ff [3];
   logic [SQ_BITS-1:0]  c_v_sq_ff [3];
   logic [SQ_BITS-1:0]  e_sq_in [3];
   logic [SQ_BITS-1:0]  a_sq_in [3];
   logic [SQ_BITS-1:0]  v_sq_in [3];

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_interp_ff, rsp_interp_in;
   logic rsp_reset_ff, rsp_reset_in;

   // handshake and pipeline advance
   logic rsp_free, c_free, c_move, b_free, b_move, req_take;
   logic clear_live;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign c_move   = c_valid_ff && rsp_free;
   assign c_free   = !c_valid_ff || rsp_free;
   assign b_move   = b_valid_ff && c_free;
   assign b_free   = !b_valid_ff || c_free;
   assign req_take = req_ch.valid && b_free;

   assign req_ch.ready          = b_free;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.interpolate    = rsp_interp_ff;
   assign rsp_ch.tracking_reset = rsp_reset_ff;

   assign b_valid_in   = b_free ? req_ch.valid : b_valid_ff;
   assign c_valid_in   = c_free ? b_valid_ff : c_valid_ff;
   assign rsp_valid_in = rsp_free ? c_valid_ff : rsp_valid_ff;

   // limit registers, stored squared
   always_ff @(posedge clock) begin
      if (reset) begin
         vel_sq_ff   <= limit_sq(VEL_MATCH_RESET);
         still_sq_ff <= limit_sq(STILL_RESET);
         jump_sq_ff  <= limit_sq(JUMP_RESET);
         near_sq_ff  <= limit_sq(NEAR_RESET);
         far_sq_ff   <= limit_sq(FAR_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VEL_MATCH: vel_sq_ff   <= limit_sq(csr_wdata);
            CSR_STILL:     still_sq_ff <= limit_sq(csr_wdata);
            CSR_JUMP:      jump_sq_ff  <= limit_sq(csr_wdata);
            CSR_NEAR:      near_sq_ff  <= limit_sq(csr_wdata);
            CSR_FAR:       far_sq_ff   <= limit_sq(csr_wdata);
            default: ;
         endcase
      end
   end

   // stage two: distances and threshold rules
   logic [SUM_BITS-1:0] e2, a2, v2;
   logic v_match, e_near, a_near, a_still, e_still, e_far, a_far, v_jump, a_jump;
   logic smooth, jump;

   always_comb begin
      e2 = SUM_BITS'(c_e_sq_ff[0]) + SUM_BITS'(c_e_sq_ff[1]) + SUM_BITS'(c_e_sq_ff[2]);
      a2 = SUM_BITS'(c_a_sq_ff[0]) + SUM_BITS'(c_a_sq_ff[1]) + SUM_BITS'(c_a_sq_ff[2]);
      v2 = SUM_BITS'(c_v_sq_ff[0]) + SUM_BITS'(c_v_sq_ff[1]) + SUM_BITS'(c_v_sq_ff[2]);
      v_match = v2 <= SUM_BITS'(vel_sq_ff);
      e_near  = e2 <= SUM_BITS'(near_sq_ff);
      a_near  = a2 <= SUM_BITS'(near_sq_ff);
      a_still = a2 <= SUM_BITS'(still_sq_ff);
      e_still = e2 <= SUM_BITS'(still_sq_ff);
      e_far   = e2 <= SUM_BITS'(far_sq_ff);
      a_far   = a2 <= SUM_BITS'(far_sq_ff);
      v_jump  = v2 <= SUM_BITS'(jump_sq_ff);
      a_jump  = a2 <= SUM_BITS'(jump_sq_ff);
      smooth  = (v_match && e_near && a_near) || (a_still && e_far) || (e_still && a_far);
      jump    = !smooth && (!v_jump || !a_jump || !e_far);
      clear_live = c_valid_ff && c_flags_ff.tracked && jump;

      // overrides: forced cut wins over forced interpolation
      rsp_reset_in = c_flags_ff.tracked && jump;
      if (c_flags_ff.force_cut) begin
         rsp_interp_in = 1'b0;
      end else if (c_flags_ff.force_interp) begin
         rsp_interp_in = 1'b1;
      end else begin
         rsp_interp_in = c_flags_ff.tracked && !jump;
      end
   end

   // stage one: prediction errors and velocity difference, squared
   logic signed [ERR_W-1:0] e_keep, e_clr, a_keep, a_clr, v_diff;
   logic signed [MOT_W-1:0] eye_mot_in [3];
   logic signed [MOT_W-1:0] at_mot_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_keep = ERR_W'(last_eye_ff[i]) + ERR_W'(eye_mot_ff[i]) - ERR_W'(b_eye_ff[i]);
         e_clr  = ERR_W'(last_eye_ff[i]) - ERR_W'(b_eye_ff[i]);
         a_keep = ERR_W'(last_at_ff[i]) + ERR_W'(at_mot_ff[i]) - ERR_W'(b_at_ff[i]);
         a_clr  = ERR_W'(last_at_ff[i]) - ERR_W'(b_at_ff[i]);
         eye_mot_in[i] = MOT_W'(b_eye_ff[i]) - MOT_W'(last_eye_ff[i]);
         at_mot_in[i]  = MOT_W'(b_at_ff[i]) - MOT_W'(last_at_ff[i]);
         v_diff = ERR_W'(eye_mot_in[i]) - ERR_W'(at_mot_in[i]);
         // previous frame's clear decides which error pair holds
         e_sq_in[i] = clear_live ? sq(sat_mag(e_clr)) : sq(sat_mag(e_keep));
         a_sq_in[i] = clear_live ? sq(sat_mag(a_clr)) : sq(sat_mag(a_keep));
         v_sq_in[i] = sq(sat_mag(v_diff));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // tracking state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            last_eye_ff[i] <= '0;
            last_at_ff[i]  <= '0;
            eye_mot_ff[i]  <= '0;
            at_mot_ff[i]   <= '0;
         end
      end else if (b_move && b_flags_ff.tracked) begin
         for (int i = 0; i < 3; i++) begin
            last_eye_ff[i] <= b_eye_ff[i];
            last_at_ff[i]  <= b_at_ff[i];
            eye_mot_ff[i]  <= eye_mot_in[i];
            at_mot_ff[i]   <= at_mot_in[i];
         end
      end else if (c_move && clear_live) begin
         for (int i = 0; i < 3; i++) begin
            eye_mot_ff[i] <= '0;
            at_mot_ff[i]  <= '0;
         end
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         b_eye_ff[0] <= req_ch.eye_x;
         b_eye_ff[1] <= req_ch.eye_y;
         b_eye_ff[2] <= req_ch.eye_z;
         b_at_ff[0]  <= req_ch.at_x;
         b_at_ff[1]  <= req_ch.at_y;
         b_at_ff[2]  <= req_ch.at_z;
         b_flags_ff.tracked      <= req_ch.perspective && !req_ch.ignore_tracking;
         b_flags_ff.force_interp <= req_ch.force_interpolate;
         b_flags_ff.force_cut    <= req_ch.force_skip || req_ch.leaving_pause;
      end
   end

   // stage two payload
   always_ff @(posedge clock) begin
      if (b_move) begin
         c_flags_ff <= b_flags_ff;
         for (int i = 0; i < 3; i++) begin
            c_e_sq_ff[i] <= e_sq_in[i];
            c_a_sq_ff[i] <= a_sq_in[i];
            c_v_sq_ff[i] <= v_sq_in[i];
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (c_move) begin
         rsp_interp_ff <= rsp_interp_in;
         rsp_reset_ff  <= rsp_reset_in;
      end
   end

endmodule
